// ----- rtl/hmbd_pkg.sv -----
// Shared constants and types, including the decode page map, for the memory bus decoder.
package hmbd_pkg;

  localparam int unsigned CartBytes     = 4194304;
  localparam int unsigned WorkBytes     = 262144;
  localparam int unsigned VideoBytes    = 98304;
  localparam int unsigned InternalBytes = 32768;
  localparam int unsigned BootBytes     = 16384;
  localparam int unsigned SmallBytes    = 1024;

  localparam logic [1:0] OpRead    = 2'd0;
  localparam logic [1:0] OpWrite   = 2'd1;
  localparam logic [1:0] OpPreload = 2'd2;

  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeHalf = 2'd1;

  localparam logic [1:0] FaultOk       = 2'd0;
  localparam logic [1:0] FaultRange    = 2'd1;
  localparam logic [1:0] FaultReadOnly = 2'd2;
  localparam logic [1:0] FaultUnmapped = 2'd3;

  localparam logic [7:0] PageBoot     = 8'd0;
  localparam logic [7:0] PageWork     = 8'd2;
  localparam logic [7:0] PageInternal = 8'd3;
  localparam logic [7:0] PageIo       = 8'd4;
  localparam logic [7:0] PagePalette  = 8'd5;
  localparam logic [7:0] PageVideo    = 8'd6;
  localparam logic [7:0] PageObject   = 8'd7;
  localparam logic [7:0] PageCartLo   = 8'd8;
  localparam logic [7:0] PageCartHi   = 8'd9;

  localparam logic [9:0] IoPresetAddr = 10'h130;
  localparam logic [7:0] IoPresetVal  = 8'hFF;

  // One byte operation issued by the controller.
  typedef struct packed {
    logic        go;      // perform a byte operation this cycle
    logic        wr;      // write (else read)
    logic        preload; // ROM writes allowed
    logic [31:0] addr;    // byte address
    logic [7:0]  data;    // write byte
    logic [1:0]  lane;    // load lane for read data
    logic        force_range; // half write crossing page end: range fault only
    logic        clear;   // start of a new beat: clear load/fault/changed
  } hmbd_cmd_t;

  typedef struct packed {
    logic clr_busy; // clearing pass still running
  } hmbd_status_t;

endpackage

// ----- rtl/hmbd_if.sv -----
// Valid/ready channel interfaces for the bus decoder.
interface hmbd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  access_size;
  logic [31:0] bus_address;
  logic [31:0] store_data;
  modport source (output valid, opcode, access_size, bus_address, store_data, input ready);
  modport sink (input valid, opcode, access_size, bus_address, store_data, output ready);
endinterface

interface hmbd_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] load_data;
  logic [1:0]  fault;
  logic [3:0]  reload_changed;
  logic [15:0] reload_zero;
  logic [15:0] reload_one;
  logic [15:0] reload_two;
  logic [15:0] reload_three;
  modport source (output valid, load_data, fault, reload_changed, reload_zero, reload_one,
                  reload_two, reload_three, input ready);
  modport sink (input valid, load_data, fault, reload_changed, reload_zero, reload_one,
                reload_two, reload_three, output ready);
endinterface

// ----- rtl/hmbd_datapath.sv -----
// Byte datapath: page decode, memories, timer reload registers, result assembly.
module hmbd_datapath #(
  parameter int unsigned CART_BYTES     = hmbd_pkg::CartBytes,
  parameter int unsigned WORK_BYTES     = hmbd_pkg::WorkBytes,
  parameter int unsigned VIDEO_BYTES    = hmbd_pkg::VideoBytes,
  parameter int unsigned INTERNAL_BYTES = hmbd_pkg::InternalBytes,
  parameter int unsigned BOOT_BYTES     = hmbd_pkg::BootBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hmbd_pkg::hmbd_cmd_t  cmd_i,
  output hmbd_pkg::hmbd_status_t status_o,
  output logic [31:0]          load_o,
  output logic [1:0]           fault_o,
  output logic [3:0]           changed_o,
  output logic [15:0]          reload_o [4]
);
  localparam int unsigned CartAw  = $clog2(CART_BYTES);
  localparam int unsigned WorkAw  = $clog2(WORK_BYTES);
  localparam int unsigned VideoAw = $clog2(VIDEO_BYTES);
  localparam int unsigned IntAw   = $clog2(INTERNAL_BYTES);
  localparam int unsigned BootAw  = $clog2(BOOT_BYTES);
  localparam int unsigned SmallAw = $clog2(hmbd_pkg::SmallBytes);
  // clearing pass spans the largest cleared RAM
  localparam int unsigned ClrWv    = (WORK_BYTES > VIDEO_BYTES) ? WORK_BYTES : VIDEO_BYTES;
  localparam int unsigned ClrBytes = (ClrWv > INTERNAL_BYTES) ? ClrWv : INTERNAL_BYTES;
  localparam int unsigned ClrAw    = $clog2(ClrBytes);

  logic [7:0] boot_mem  [BOOT_BYTES];
  logic [7:0] work_mem  [WORK_BYTES];
  logic [7:0] int_mem   [INTERNAL_BYTES];
  logic [7:0] io_mem    [hmbd_pkg::SmallBytes];
  logic [7:0] pal_mem   [hmbd_pkg::SmallBytes];
  logic [7:0] vid_mem   [VIDEO_BYTES];
  logic [7:0] obj_mem   [hmbd_pkg::SmallBytes];
  logic [7:0] cart_mem  [CART_BYTES];

  // Clearing pass over the RAMs after reset.
  logic [ClrAw:0] clr_q, clr_d;
  logic           clr_busy;
  assign clr_busy = (clr_q < (ClrAw+1)'(ClrBytes));
  assign clr_d    = clr_busy ? clr_q + (ClrAw+1)'(1) : clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else clr_q <= clr_d;
  end
  assign status_o.clr_busy = clr_busy;

  // Decode.
  logic [7:0]  page;
  logic [23:0] off;
  logic [24:0] cart_idx;
  logic [1:0]  loc_fault;
  logic        timer_hit, rom_page;
  logic [1:0]  timer_sel;
  assign page     = cmd_i.addr[31:24];
  assign off      = cmd_i.addr[23:0];
  assign cart_idx = {page == hmbd_pkg::PageCartHi, off};
  assign rom_page = page == hmbd_pkg::PageBoot || page == hmbd_pkg::PageCartLo ||
                    page == hmbd_pkg::PageCartHi;
  assign timer_hit = page == hmbd_pkg::PageIo && off[23:4] == 20'h00010 && !off[1];
  assign timer_sel = off[3:2];

  always_comb begin
    unique case (page)
      hmbd_pkg::PageBoot:     loc_fault = (off >= 24'(BOOT_BYTES)) ?
                                          hmbd_pkg::FaultRange : hmbd_pkg::FaultOk;
      hmbd_pkg::PageWork:     loc_fault = (off >= 24'(WORK_BYTES)) ?
                                          hmbd_pkg::FaultRange : hmbd_pkg::FaultOk;
      hmbd_pkg::PageInternal: loc_fault = ({9'd0, off[14:0]} >= 24'(INTERNAL_BYTES)) ?
                                          hmbd_pkg::FaultRange : hmbd_pkg::FaultOk;
      hmbd_pkg::PageIo, hmbd_pkg::PagePalette, hmbd_pkg::PageObject:
                              loc_fault = (off >= 24'(hmbd_pkg::SmallBytes)) ?
                                          hmbd_pkg::FaultRange : hmbd_pkg::FaultOk;
      hmbd_pkg::PageVideo:    loc_fault = (off >= 24'(VIDEO_BYTES)) ?
                                          hmbd_pkg::FaultRange : hmbd_pkg::FaultOk;
      hmbd_pkg::PageCartLo, hmbd_pkg::PageCartHi:
                              loc_fault = ({7'd0, cart_idx} >= 32'(CART_BYTES)) ?
                                          hmbd_pkg::FaultRange : hmbd_pkg::FaultOk;
      default:                loc_fault = hmbd_pkg::FaultUnmapped;
    endcase
  end

  logic [1:0] byte_fault;
  logic       do_store;
  always_comb begin
    byte_fault = hmbd_pkg::FaultOk;
    do_store   = 1'b0;
    if (cmd_i.force_range) begin
      byte_fault = hmbd_pkg::FaultRange;
    end else if (cmd_i.wr && rom_page && !cmd_i.preload) begin
      byte_fault = hmbd_pkg::FaultReadOnly;
    end else if (cmd_i.wr && timer_hit) begin
      byte_fault = hmbd_pkg::FaultOk;
    end else begin
      byte_fault = loc_fault;
      do_store   = cmd_i.wr && loc_fault == hmbd_pkg::FaultOk;
    end
  end

  logic       wen;
  logic [7:0] wdat;
  logic [23:0] waddr;
  assign wen   = (cmd_i.go && do_store) || clr_busy;
  assign wdat  = (clr_busy && clr_q[ClrAw-1:0] == ClrAw'(hmbd_pkg::IoPresetAddr)) ?
                 hmbd_pkg::IoPresetVal : (clr_busy ? 8'd0 : cmd_i.data);
  assign waddr = clr_busy ? 24'(clr_q[ClrAw-1:0]) : off;

  // Memories: one write and one registered read each.
  logic [7:0] rd_boot, rd_work, rd_int, rd_io, rd_pal, rd_vid, rd_obj, rd_cart;
  always_ff @(posedge clk_i) begin
    if (cmd_i.go && do_store && page == hmbd_pkg::PageBoot) boot_mem[off[BootAw-1:0]] <= wdat;
    if (cmd_i.go && do_store && (page == hmbd_pkg::PageCartLo || page == hmbd_pkg::PageCartHi))
      cart_mem[cart_idx[CartAw-1:0]] <= wdat;
    if (wen && ((clr_busy && waddr < 24'(WORK_BYTES)) || (!clr_busy &&
        page == hmbd_pkg::PageWork))) work_mem[waddr[WorkAw-1:0]] <= clr_busy ? 8'd0 : wdat;
    if (wen && ((clr_busy && waddr < 24'(INTERNAL_BYTES)) || (!clr_busy &&
        page == hmbd_pkg::PageInternal))) int_mem[waddr[IntAw-1:0]] <= clr_busy ? 8'd0 : wdat;
    if (wen && ((clr_busy && waddr < 24'(hmbd_pkg::SmallBytes)) || (!clr_busy &&
        page == hmbd_pkg::PageIo))) io_mem[waddr[SmallAw-1:0]] <= wdat;
    if (wen && ((clr_busy && waddr < 24'(hmbd_pkg::SmallBytes)) || (!clr_busy &&
        page == hmbd_pkg::PagePalette))) pal_mem[waddr[SmallAw-1:0]] <= clr_busy ? 8'd0 : wdat;
    if (wen && ((clr_busy && waddr < 24'(VIDEO_BYTES)) || (!clr_busy &&
        page == hmbd_pkg::PageVideo))) vid_mem[waddr[VideoAw-1:0]] <= clr_busy ? 8'd0 : wdat;
    if (wen && ((clr_busy && waddr < 24'(hmbd_pkg::SmallBytes)) || (!clr_busy &&
        page == hmbd_pkg::PageObject))) obj_mem[waddr[SmallAw-1:0]] <= clr_busy ? 8'd0 : wdat;
    rd_boot <= boot_mem[off[BootAw-1:0]];
    rd_cart <= cart_mem[cart_idx[CartAw-1:0]];
    rd_work <= work_mem[off[WorkAw-1:0]];
    rd_int  <= int_mem[off[IntAw-1:0]];
    rd_io   <= io_mem[off[SmallAw-1:0]];
    rd_pal  <= pal_mem[off[SmallAw-1:0]];
    rd_vid  <= vid_mem[off[VideoAw-1:0]];
    rd_obj  <= obj_mem[off[SmallAw-1:0]];
  end

  // The read byte passes the memory read register and lands in its lane of the load register.
  logic       rd_pend_q;
  logic [7:0] rd_page_q;
  logic [1:0] rd_lane_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_pend_q <= 1'b0;
    else rd_pend_q <= cmd_i.go && !cmd_i.wr && byte_fault == hmbd_pkg::FaultOk;
  end
  always_ff @(posedge clk_i) begin
    rd_page_q <= page;
    rd_lane_q <= cmd_i.lane;
  end

  logic [7:0] rd_byte;
  always_comb begin
    unique case (rd_page_q)
      hmbd_pkg::PageBoot:                          rd_byte = rd_boot;
      hmbd_pkg::PageWork:                          rd_byte = rd_work;
      hmbd_pkg::PageInternal:                      rd_byte = rd_int;
      hmbd_pkg::PageIo:                            rd_byte = rd_io;
      hmbd_pkg::PagePalette:                       rd_byte = rd_pal;
      hmbd_pkg::PageVideo:                         rd_byte = rd_vid;
      hmbd_pkg::PageObject:                        rd_byte = rd_obj;
      hmbd_pkg::PageCartLo, hmbd_pkg::PageCartHi:  rd_byte = rd_cart;
      default:                                     rd_byte = 8'd0;
    endcase
  end

  logic [31:0] load_q, load_d;
  logic [1:0]  fault_q, fault_d;
  logic [15:0] rel_q [4];
  logic [15:0] rel_d [4];
  logic [15:0] base_q [4];
  always_comb begin
    load_d  = cmd_i.clear ? 32'd0 : load_q;
    fault_d = cmd_i.clear ? hmbd_pkg::FaultOk : fault_q;
    if (rd_pend_q) load_d[8*rd_lane_q +: 8] = rd_byte;
    if (cmd_i.go && fault_d == hmbd_pkg::FaultOk) fault_d = byte_fault;
    for (int t = 0; t < 4; t++) rel_d[t] = rel_q[t];
    if (cmd_i.go && cmd_i.wr && !cmd_i.force_range && timer_hit &&
        !(rom_page && !cmd_i.preload)) begin
      if (off[0]) rel_d[timer_sel][15:8] = cmd_i.data;
      else rel_d[timer_sel][7:0] = cmd_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q <= hmbd_pkg::FaultOk;
      for (int t = 0; t < 4; t++) begin
        rel_q[t]  <= '0;
        base_q[t] <= '0;
      end
    end else begin
      fault_q <= fault_d;
      for (int t = 0; t < 4; t++) begin
        rel_q[t] <= rel_d[t];
        if (cmd_i.clear) base_q[t] <= rel_q[t];
      end
    end
  end
  always_ff @(posedge clk_i) load_q <= load_d;

  assign load_o  = load_q;
  assign fault_o = fault_q;
  always_comb begin
    for (int t = 0; t < 4; t++) begin
      changed_o[t] = rel_q[t] != base_q[t];
      reload_o[t]  = rel_q[t];
    end
  end

  hmbd_clr_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_busy |=> !clr_busy) else $error("clearing pass restarted");
  hmbd_rd_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> $past(cmd_i.go && !cmd_i.wr)) else $error("stray read return");
  hmbd_ro_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.go && byte_fault != hmbd_pkg::FaultOk) |-> !do_store)
    else $error("faulting byte stored");
endmodule

// ----- rtl/hmbd_ctrl.sv -----
// Sequencer: splits an access into byte operations and runs the handshake.
module hmbd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             opcode_i,
  input  logic [1:0]             access_size_i,
  input  logic [31:0]            bus_address_i,
  input  logic [31:0]            store_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  hmbd_pkg::hmbd_status_t status_i,
  output hmbd_pkg::hmbd_cmd_t    cmd_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StWait = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]  st_q, st_d;
  logic [2:0]  idx_q, idx_d;
  logic        dup_q, dup_d;
  logic [2:0]  cnt_q;
  logic        wr_q, pre_q;
  logic [31:0] addr_q, data_q;
  logic [1:0]  size_q;

  logic [2:0] nbytes;
  assign nbytes = access_size_i == hmbd_pkg::SizeByte ? 3'd1 :
                  (access_size_i == hmbd_pkg::SizeHalf ? 3'd2 : 3'd4);

  assign in_ready_o  = st_q == StIdle && !status_i.clr_busy;
  assign out_valid_o = st_q == StDone;

  // Per-byte address and data. Writes to pages 5..7 store halfwords: a byte
  // write doubles into the even halfword; an odd halfword stays unaligned.
  logic [31:0] half_a, b_addr;
  logic [15:0] half_v;
  logic [7:0]  b_data;
  logic        vpage, first_of_half, range_only, spill;
  always_comb begin
    half_a = addr_q + (idx_q[1] ? 32'd2 : 32'd0);
    half_v = idx_q[1] ? data_q[31:16] : data_q[15:0];
    vpage  = half_a[31:24] >= hmbd_pkg::PagePalette && half_a[31:24] <= hmbd_pkg::PageObject;
    first_of_half = !idx_q[0];
    range_only = 1'b0;
    spill      = 1'b0;
    if (!wr_q) begin
      b_addr = addr_q + 32'(idx_q);
      b_data = 8'd0;
    end else if (size_q == hmbd_pkg::SizeByte) begin
      if (addr_q[31:24] >= hmbd_pkg::PagePalette && addr_q[31:24] <= hmbd_pkg::PageObject)
      begin
        b_addr = {addr_q[31:1], idx_q[0]};
        b_data = data_q[7:0];
      end else begin
        b_addr = addr_q;
        b_data = data_q[7:0];
      end
    end else begin
      b_addr = half_a + 32'(idx_q[0]);
      b_data = first_of_half ? half_v[7:0] : half_v[15:8];
      if (vpage && !first_of_half) begin
        b_addr = {half_a[31:24], half_a[23:0] + 24'd1};
        range_only = half_a[23:0] == 24'hFFFFFF;
      end else if (!vpage && !first_of_half &&
                   b_addr[31:24] >= hmbd_pkg::PagePalette &&
                   b_addr[31:24] <= hmbd_pkg::PageObject) begin
        // upper byte spills from I/O into palette: doubled into both bytes of its
        // halfword
        spill  = 1'b1;
        b_addr = {b_addr[31:1], dup_q};
      end
    end
  end

  always_comb begin
    st_d  = st_q;
    idx_d = idx_q;
    dup_d = 1'b0;
    unique case (st_q)
      StIdle: if (in_valid_i && in_ready_o) begin
        st_d  = StRun;
        idx_d = 3'd0;
      end
      StRun: begin
        if (spill && !dup_q) begin
          dup_d = 1'b1;
        end else begin
          idx_d = idx_q + 3'd1;
          if (idx_d == cnt_q) st_d = StWait;
        end
      end
      StWait: st_d = StDone;
      StDone: if (out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      idx_q <= '0;
      dup_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
      dup_q <= dup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && in_valid_i && in_ready_o) begin
      wr_q   <= opcode_i == hmbd_pkg::OpWrite || opcode_i == hmbd_pkg::OpPreload;
      pre_q  <= opcode_i == hmbd_pkg::OpPreload;
      addr_q <= bus_address_i;
      data_q <= store_data_i;
      size_q <= access_size_i;
      // byte write to pages 5..7 becomes a two-byte halfword store
      cnt_q  <= (nbytes == 3'd1 && (opcode_i == hmbd_pkg::OpWrite ||
                 opcode_i == hmbd_pkg::OpPreload) && bus_address_i[31:24] >=
                 hmbd_pkg::PagePalette && bus_address_i[31:24] <= hmbd_pkg::PageObject) ?
                3'd2 : nbytes;
    end
  end

  always_comb begin
    cmd_o.go          = st_q == StRun;
    cmd_o.wr          = wr_q;
    cmd_o.preload     = pre_q;
    cmd_o.addr        = b_addr;
    cmd_o.data        = b_data;
    cmd_o.lane        = idx_q[1:0];
    cmd_o.force_range = range_only;
    cmd_o.clear       = st_q == StIdle && in_valid_i && in_ready_o;
  end

  hmbd_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.clr_busy |-> !in_ready_o) else $error("accept during clear");
  hmbd_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StRun |-> idx_q < cnt_q) else $error("byte index overrun");
  hmbd_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StDone && !out_ready_i) |=> st_q == StDone) else $error("result lost");
endmodule

// ----- rtl/handheld_memory_bus_decoder.sv -----
// Top level of the handheld memory bus decoder.
//  channel | dir | payload                                   | beat when
//  req     | in  | opcode, access_size, bus_address, data    | valid & ready
//  rsp     | out | load_data, fault, reload_changed, reloads | valid & ready
// An access runs as byte operations on the byte memories, one per byte: 1, 2
// or 4; a byte write to pages 5..7 also writes the other byte of its halfword,
// and a write whose upper byte spills from I/O into palette writes that byte
// into both bytes of its halfword. The last read byte lands in the wait state,
// the result shows in the done state, and a new request is taken only in idle.
// After reset a clearing pass, one cycle per byte of the largest of work,
// video and internal RAM (262144 by default), zeroes the RAMs and presets I/O
// byte 0x130; no beat is taken meanwhile.
// A stalled result holds until taken; no new request is taken until then.
module handheld_memory_bus_decoder #(
  parameter int unsigned CART_BYTES     = hmbd_pkg::CartBytes,
  parameter int unsigned WORK_BYTES     = hmbd_pkg::WorkBytes,
  parameter int unsigned VIDEO_BYTES    = hmbd_pkg::VideoBytes,
  parameter int unsigned INTERNAL_BYTES = hmbd_pkg::InternalBytes,
  parameter int unsigned BOOT_BYTES     = hmbd_pkg::BootBytes
) (
  input logic        clk_i,
  input logic        rst_ni,
  hmbd_req_if.sink   req,
  hmbd_rsp_if.source rsp
);
  hmbd_pkg::hmbd_cmd_t    cmd;
  hmbd_pkg::hmbd_status_t status;
  logic [15:0]            reload [4];

  // Sequencer splits each beat into byte operations.
  hmbd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .opcode_i(req.opcode), .access_size_i(req.access_size),
    .bus_address_i(req.bus_address), .store_data_i(req.store_data),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .status_i(status), .cmd_o(cmd)
  );

  // Datapath holds memories, timer reloads and the result registers.
  hmbd_datapath #(
    .CART_BYTES(CART_BYTES), .WORK_BYTES(WORK_BYTES), .VIDEO_BYTES(VIDEO_BYTES),
    .INTERNAL_BYTES(INTERNAL_BYTES), .BOOT_BYTES(BOOT_BYTES)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .load_o(rsp.load_data), .fault_o(rsp.fault), .changed_o(rsp.reload_changed),
    .reload_o(reload)
  );

  assign rsp.reload_zero  = reload[0];
  assign rsp.reload_one   = reload[1];
  assign rsp.reload_two   = reload[2];
  assign rsp.reload_three = reload[3];
endmodule

// ----- tb/handheld_memory_bus_decoder_tb.sv -----
// Self-checking testbench for the handheld memory bus decoder.
module handheld_memory_bus_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Store selector used to key the byte memory shadow.
  typedef enum logic [3:0] {
    MemBoot, MemWork, MemInternal, MemIo, MemPalette, MemVideo, MemObject, MemCart
  } mem_kind_e;

  // One predicted response beat.
  typedef struct {
    logic [31:0] load;
    logic [1:0]  fault;
    logic [3:0]  changed;
    logic [15:0] reload [4];
  } bus_result_t;

  localparam logic [1:0] OpSpare   = 2'd3;
  localparam logic [1:0] SizeWord  = 2'd2;
  localparam logic [1:0] SizeSpare = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  hmbd_req_if req_ch ();
  hmbd_rsp_if rsp_ch ();

  handheld_memory_bus_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of all byte stores, keyed by {store, index}. Missing entries hold
  // their reset value.
  logic [7:0]  shadow_mem [logic [35:0]];
  logic [15:0] shadow_reload [4];
  logic [1:0]  beat_fault;
  logic        beat_preload;

  bus_result_t pending_results [$];
  int unsigned error_count = 0;

  // ---------------------------------------------------------------------------
  // Access predictor
  // ---------------------------------------------------------------------------

  // Map a byte address onto a store cell; returns the fault for that byte.
  function automatic logic [1:0] find_cell(input logic [31:0] a, output logic [35:0] key);
    logic [7:0]  page;
    logic [31:0] off;
    page = a[31:24];
    off  = {8'h00, a[23:0]};
    key  = '0;
    case (page)
      hmbd_pkg::PageBoot: begin
        if (off >= hmbd_pkg::BootBytes) return hmbd_pkg::FaultRange;
        key = {MemBoot, off};
      end
      hmbd_pkg::PageWork: begin
        if (off >= hmbd_pkg::WorkBytes) return hmbd_pkg::FaultRange;
        key = {MemWork, off};
      end
      hmbd_pkg::PageInternal: begin
        // 32 KiB mirror across the whole page
        if ((off & 32'h7FFF) >= hmbd_pkg::InternalBytes) return hmbd_pkg::FaultRange;
        key = {MemInternal, off & 32'h7FFF};
      end
      hmbd_pkg::PageIo: begin
        if (off >= hmbd_pkg::SmallBytes) return hmbd_pkg::FaultRange;
        key = {MemIo, off};
      end
      hmbd_pkg::PagePalette: begin
        if (off >= hmbd_pkg::SmallBytes) return hmbd_pkg::FaultRange;
        key = {MemPalette, off};
      end
      hmbd_pkg::PageVideo: begin
        if (off >= hmbd_pkg::VideoBytes) return hmbd_pkg::FaultRange;
        key = {MemVideo, off};
      end
      hmbd_pkg::PageObject: begin
        if (off >= hmbd_pkg::SmallBytes) return hmbd_pkg::FaultRange;
        key = {MemObject, off};
      end
      hmbd_pkg::PageCartLo, hmbd_pkg::PageCartHi: begin
        if (page == hmbd_pkg::PageCartHi) off = off + 32'h0100_0000;
        if (off >= hmbd_pkg::CartBytes) return hmbd_pkg::FaultRange;
        key = {MemCart, off};
      end
      default: return hmbd_pkg::FaultUnmapped;
    endcase
    return hmbd_pkg::FaultOk;
  endfunction

  function automatic void note_fault(input logic [1:0] f);
    if (beat_fault == hmbd_pkg::FaultOk) beat_fault = f;
  endfunction

  function automatic logic [7:0] cell_value(input logic [35:0] key);
    if (shadow_mem.exists(key)) return shadow_mem[key];
    if (key == {MemIo, 22'd0, hmbd_pkg::IoPresetAddr}) return hmbd_pkg::IoPresetVal;
    return 8'h00;
  endfunction

  function automatic logic [7:0] load_byte(input logic [31:0] a);
    logic [35:0] key;
    logic [1:0]  f;
    f = find_cell(a, key);
    if (f != hmbd_pkg::FaultOk) begin
      note_fault(f);
      return 8'h00;
    end
    return cell_value(key);
  endfunction

  function automatic void put_byte(input logic [31:0] a, input logic [7:0] v);
    logic [35:0] key;
    logic [1:0]  f;
    f = find_cell(a, key);
    if (f != hmbd_pkg::FaultOk) note_fault(f);
    else shadow_mem[key] = v;
  endfunction

  function automatic void write_byte_path(input logic [31:0] a, input logic [7:0] v);
    logic [7:0]  page;
    logic [23:0] off;
    int          t;
    page = a[31:24];
    off  = a[23:0];
    if ((page == hmbd_pkg::PageBoot || page == hmbd_pkg::PageCartLo ||
         page == hmbd_pkg::PageCartHi) && !beat_preload) begin
      note_fault(hmbd_pkg::FaultReadOnly);
      return;
    end
    // timer reload low/high bytes are kept aside, not in I/O
    if (page == hmbd_pkg::PageIo && off >= 24'h100 && off < 24'h110 && off[1] == 1'b0) begin
      t = int'(off[3:2]);
      if (off[0]) shadow_reload[t][15:8] = v;
      else shadow_reload[t][7:0] = v;
      return;
    end
    // byte writes to palette/video/object land on both halves of the halfword
    if (page >= hmbd_pkg::PagePalette && page <= hmbd_pkg::PageObject) begin
      write_half_path({a[31:1], 1'b0}, {v, v});
      return;
    end
    put_byte(a, v);
  endfunction

  function automatic void write_half_path(input logic [31:0] a, input logic [15:0] v);
    logic [7:0] page;
    page = a[31:24];
    if (page >= hmbd_pkg::PagePalette && page <= hmbd_pkg::PageObject) begin
      put_byte(a, v[7:0]);
      // the upper byte may not spill into the next page
      if (a[23:0] == 24'hFF_FFFF) note_fault(hmbd_pkg::FaultRange);
      else put_byte(a + 32'd1, v[15:8]);
      return;
    end
    write_byte_path(a, v[7:0]);
    write_byte_path(a + 32'd1, v[15:8]);
  endfunction

  function automatic bus_result_t predict_access(input logic [1:0] op, input logic [1:0] size,
                                                 input logic [31:0] a, input logic [31:0] d);
    bus_result_t r;
    logic [15:0] prior [4];
    int          nbytes;
    nbytes       = (size == hmbd_pkg::SizeByte) ? 1 : (size == hmbd_pkg::SizeHalf) ? 2 : 4;
    prior        = shadow_reload;
    beat_fault   = hmbd_pkg::FaultOk;
    beat_preload = (op == hmbd_pkg::OpPreload);
    r.load       = '0;
    if (op == hmbd_pkg::OpWrite || op == hmbd_pkg::OpPreload) begin
      if (nbytes == 1) write_byte_path(a, d[7:0]);
      else begin
        write_half_path(a, d[15:0]);
        if (nbytes == 4) write_half_path(a + 32'd2, d[31:16]);
      end
    end else begin
      for (int i = 0; i < nbytes; i++) r.load[8*i +: 8] = load_byte(a + i);
    end
    r.changed = '0;
    for (int i = 0; i < 4; i++) if (shadow_reload[i] != prior[i]) r.changed[i] = 1'b1;
    r.fault      = beat_fault;
    r.reload     = shadow_reload;
    beat_preload = 1'b0;
    return r;
  endfunction

  // True when a read would touch a ROM byte that was never preloaded.
  function automatic bit hits_blank_rom(input logic [1:0] size, input logic [31:0] a);
    logic [35:0] key;
    int          nbytes;
    nbytes = (size == hmbd_pkg::SizeByte) ? 1 : (size == hmbd_pkg::SizeHalf) ? 2 : 4;
    for (int i = 0; i < nbytes; i++) begin
      if (find_cell(a + i, key) == hmbd_pkg::FaultOk &&
          (key[35:32] == MemBoot || key[35:32] == MemCart) &&
          !shadow_mem.exists(key)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: bursts of back-to-back beats with random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_access(input logic [1:0] op, input logic [1:0] size,
                             input logic [31:0] a, input logic [31:0] d);
    int gap;
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.access_size <= size;
    req_ch.bus_address <= a;
    req_ch.store_data  <= d;
    do @(posedge clk_i); while (!req_ch.ready);
    pending_results.push_back(predict_access(op, size, a, d));
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 6);
      gap        = $urandom_range(1, 5);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every outstanding beat has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Response checker with its own stall pattern
  // ---------------------------------------------------------------------------
  logic [15:0] stall_pattern;
  int unsigned stall_phase;

  always @(posedge clk_i or negedge rst_ni) begin
    bus_result_t want;
    if (!rst_ni) begin
      rsp_ch.ready  <= 1'b0;
      stall_pattern <= 16'hFFFF;
      stall_phase   <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("response beat with nothing expected");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.load_data !== want.load) begin
            $error("load_data expected %h actual %h", want.load, rsp_ch.load_data);
            error_count++;
          end
          if (rsp_ch.fault !== want.fault) begin
            $error("fault expected %0d actual %0d", want.fault, rsp_ch.fault);
            error_count++;
          end
          if (rsp_ch.reload_changed !== want.changed) begin
            $error("reload_changed expected %h actual %h", want.changed,
                   rsp_ch.reload_changed);
            error_count++;
          end
          if (rsp_ch.reload_zero !== want.reload[0]) begin
            $error("reload_zero expected %h actual %h", want.reload[0], rsp_ch.reload_zero);
            error_count++;
          end
          if (rsp_ch.reload_one !== want.reload[1]) begin
            $error("reload_one expected %h actual %h", want.reload[1], rsp_ch.reload_one);
            error_count++;
          end
          if (rsp_ch.reload_two !== want.reload[2]) begin
            $error("reload_two expected %h actual %h", want.reload[2], rsp_ch.reload_two);
            error_count++;
          end
          if (rsp_ch.reload_three !== want.reload[3]) begin
            $error("reload_three expected %h actual %h", want.reload[3],
                   rsp_ch.reload_three);
            error_count++;
          end
        end
      end
      // new stall pattern at each wrap of the low phase bits; all-ones stretches included
      if (stall_phase[5:0] == 6'd63) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern <= 16'hFFFF;
          1:       stall_pattern <= 16'h00FF;
          default: stall_pattern <= 16'($urandom);
        endcase
      end
      stall_phase  <= stall_phase + 1;
      rsp_ch.ready <= stall_pattern[stall_phase[3:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill both ROM windows and read them back, including the range edges.
  task automatic test_rom_preload();
    send_access(hmbd_pkg::OpPreload, SizeWord,  32'h0000_0000, 32'hDEAD_BEEF);
    send_access(hmbd_pkg::OpPreload, SizeWord,  32'h0000_3FFC, 32'h0123_4567);
    send_access(hmbd_pkg::OpPreload, SizeWord,  32'h0800_0000, 32'hCAFE_F00D);
    // spare size = word
    send_access(hmbd_pkg::OpPreload, SizeSpare, 32'h0800_0004, 32'h89AB_CDEF);
    send_access(hmbd_pkg::OpPreload, SizeWord,  32'h083F_FFFC, 32'hA5A5_5A5A);
    // page 9 out of range
    send_access(hmbd_pkg::OpPreload, hmbd_pkg::SizeHalf, 32'h0900_0000, 32'hFFFF_FFFF);
    send_access(hmbd_pkg::OpRead,    SizeSpare, 32'h0000_0000, 32'h0);
    send_access(hmbd_pkg::OpRead,    SizeWord,  32'h0000_3FFE, 32'h0); // runs past boot end
    send_access(hmbd_pkg::OpWrite,   SizeWord,  32'h0800_0000, 32'hFFFF_FFFF); // read-only
    send_access(hmbd_pkg::OpRead,    SizeWord,  32'h0800_0000, 32'h0);
  endtask

  // Work RAM, internal mirror and the I/O preset byte.
  task automatic test_ram_pages();
    send_access(hmbd_pkg::OpWrite, SizeWord, 32'h0200_0000, 32'hFFFF_FFFF);
    send_access(hmbd_pkg::OpRead,  SizeWord, 32'h0200_0000, 32'h0);
    send_access(hmbd_pkg::OpWrite, SizeWord, 32'h03FF_8000, 32'h1357_9BDF);
    send_access(OpSpare, SizeWord, 32'h0300_0000, 32'h0);            // spare opcode = read
    send_access(hmbd_pkg::OpRead,  hmbd_pkg::SizeByte, 32'h0400_0130, 32'h0);
  endtask

  // Timer reload bytes and the neighboring I/O bytes.
  task automatic test_timer_reloads();
    send_access(hmbd_pkg::OpWrite, hmbd_pkg::SizeByte, 32'h0400_0100, 32'h0000_00AB);
    send_access(hmbd_pkg::OpWrite, SizeWord,           32'h0400_010C, 32'h1234_5678);
    send_access(hmbd_pkg::OpWrite, hmbd_pkg::SizeHalf, 32'h0400_0105, 32'h0000_C3D4);
    send_access(hmbd_pkg::OpRead,  SizeWord,           32'h0400_010C, 32'h0);
  endtask

  // Halfword-wide pages, faults and address wrap.
  task automatic test_video_faults();
    send_access(hmbd_pkg::OpWrite, hmbd_pkg::SizeByte, 32'h0500_0003, 32'h0000_005A);
    // odd halfword
    send_access(hmbd_pkg::OpWrite, hmbd_pkg::SizeHalf, 32'h0700_0001, 32'h0000_BEEF);
    // second byte out
    send_access(hmbd_pkg::OpWrite, hmbd_pkg::SizeHalf, 32'h0601_7FFF, 32'h0000_1122);
    // page end
    send_access(hmbd_pkg::OpWrite, hmbd_pkg::SizeHalf, 32'h05FF_FFFF, 32'h0000_3344);
    // I/O halfword whose upper byte lands in palette
    send_access(hmbd_pkg::OpWrite, hmbd_pkg::SizeHalf, 32'h04FF_FFFF, 32'h0000_7788);
    send_access(hmbd_pkg::OpRead,  SizeWord,           32'h0500_0000, 32'h0);
    send_access(hmbd_pkg::OpRead,  hmbd_pkg::SizeByte, 32'h0100_0000, 32'h0);
    send_access(hmbd_pkg::OpWrite, SizeWord,           32'hFF00_0000, 32'h5555_AAAA);
    // wraps to boot
    send_access(hmbd_pkg::OpRead,  SizeWord,           32'hFFFF_FFFE, 32'h0);
  endtask

  function automatic logic [31:0] pick_address();
    logic [7:0]  page;
    logic [23:0] off;
    int unsigned span;
    case ($urandom_range(0, 19))
      0, 1:       page = hmbd_pkg::PageBoot;
      2, 3, 4:    page = hmbd_pkg::PageWork;
      5:          page = hmbd_pkg::PageInternal;
      6, 7, 8:    page = hmbd_pkg::PageIo;
      9, 10:      page = hmbd_pkg::PagePalette;
      11, 12:     page = hmbd_pkg::PageVideo;
      13:         page = hmbd_pkg::PageObject;
      14, 15:     page = hmbd_pkg::PageCartLo;
      16:         page = hmbd_pkg::PageCartHi;
      17:         page = 8'd1;
      18:         page = 8'($urandom_range(10, 255));
      default:    page = 8'($urandom);
    endcase
    case (page)
      hmbd_pkg::PageBoot:     span = hmbd_pkg::BootBytes;
      hmbd_pkg::PageWork:     span = hmbd_pkg::WorkBytes;
      hmbd_pkg::PageInternal: span = 32'h8000;
      hmbd_pkg::PageVideo:    span = hmbd_pkg::VideoBytes;
      hmbd_pkg::PageCartLo:   span = hmbd_pkg::CartBytes;
      hmbd_pkg::PageIo, hmbd_pkg::PagePalette, hmbd_pkg::PageObject:
                              span = hmbd_pkg::SmallBytes;
      default:                span = 32'h0100_0000;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: off = 24'($urandom_range(0, 255));
      6:                off = 24'h100 + 24'($urandom_range(0, 31));
      7:                off = 24'(span - $urandom_range(1, 8));
      8:                off = 24'($urandom);
      default:          off = 24'hFF_FFFF - 24'($urandom_range(0, 3));
    endcase
    return {page, off};
  endfunction

  task automatic test_random_traffic(input int count);
    logic [1:0]  op;
    logic [1:0]  size;
    logic [31:0] a;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      op   = pick < 45 ? hmbd_pkg::OpRead : pick < 85 ? hmbd_pkg::OpWrite :
             pick < 95 ? hmbd_pkg::OpPreload : OpSpare;
      size = 2'($urandom_range(0, 3));
      a    = pick_address();
      // reads stay off ROM bytes that were never preloaded
      if (op == hmbd_pkg::OpRead || op == OpSpare) begin
        while (hits_blank_rom(size, a)) a = pick_address();
      end
      send_access(op, size, a, $urandom);
      if (n == count / 2) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    req_ch.valid       <= 1'b0;
    req_ch.opcode      <= hmbd_pkg::OpRead;
    req_ch.access_size <= hmbd_pkg::SizeByte;
    req_ch.bus_address <= '0;
    req_ch.store_data  <= '0;
    shadow_reload = '{default: 16'h0000};
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_rom_preload();
    test_ram_pages();
    test_timer_reloads();
    test_video_faults();
    wait_drained();
    test_random_traffic(1870);

    req_ch.valid <= 1'b0;
    for (int c = 0; c < 200000 && pending_results.size() != 0; c++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d responses never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("handheld_memory_bus_decoder_tb: PASS");
    end else begin
      $display("handheld_memory_bus_decoder_tb: FAIL");
    end
    $finish;
  end

  // Covers the post-reset clearing pass plus a slow run many times over.
  initial begin
    #20ms;
    $display("handheld_memory_bus_decoder_tb: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hmbd_pkg.sv
rtl/hmbd_if.sv
rtl/hmbd_datapath.sv
rtl/hmbd_ctrl.sv
rtl/handheld_memory_bus_decoder.sv
tb/handheld_memory_bus_decoder_tb.sv
